@@ design/nia_pkg.sv @@
// Shared types, register map and reset values for the normalization blend block.
package nia_pkg;

  localparam int unsigned MAX_ELEMS_DEF = 64;
  localparam int CFG_AW = 4;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_EPS   = 2'd1;
  localparam logic [1:0] REG_ALPHA = 2'd2;
  localparam logic [1:0] REG_BETA  = 2'd3;

  localparam logic        MODE_RST  = 1'b0;
  localparam logic [23:0] EPS_RST   = 24'd168;
  localparam logic [15:0] ALPHA_RST = 16'd256;
  localparam logic [15:0] BETA_RST  = 16'd0;

  typedef struct packed {
    logic signed [15:0] x_value;
    logic signed [15:0] prior_y;
    logic signed [15:0] scale;
    logic signed [15:0] bias;
    logic signed [15:0] mean_value;
    logic [15:0]        variance_value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic signed [15:0] y_value;
    logic               last_out;
    logic               overrun;
  } out_t;

endpackage

@@ design/norm_inference_affine_blend.sv @@
// Top level: Q8.8 normalization inference with alpha/beta blend, per-channel and layer modes.
// Per-channel mode: an item passes a 32-step square root followed by a 64-step
// divider for the inverse standard deviation, then the multiply chain; a new
// item is taken only once its result has been issued. Layer mode: elements are
// taken back to back and written to the element buffer while it has room; the
// element marked last closes the sample and starts the statistics (three products,
// mean and variance divides of 64 steps, square root, inverse divide); then the
// buffered elements leave one by one (buffer read, multiply chain), stalled while out_ready is low.
// No reset sweep: buffer entries are only read after being written in the same sample.
module norm_inference_affine_blend #(
  parameter int unsigned MAX_ELEMS = nia_pkg::MAX_ELEMS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  nia_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output nia_pkg::out_t             out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [nia_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int ADDR_W = $clog2(MAX_ELEMS);
  localparam int CNT_W  = $clog2(MAX_ELEMS + 1);
  localparam int SUM_W  = 16 + CNT_W;
  localparam int SQ_W   = 31 + CNT_W;
  localparam int DQ_W   = CNT_W + SQ_W;
  localparam int DD_W   = 2 * CNT_W;
  localparam int SS_W   = 2 * SUM_W;
  localparam int NUM_W  = SS_W;
  localparam int A_W    = SUM_W + 9;
  localparam int DIV_W  = 64;
  localparam int DSR_W  = 32;
  localparam int V_W    = 40;
  localparam int INV_W  = 37;
  localparam int D_W    = 26;
  localparam int PLO_W  = 51;
  localparam int PHI_W  = 40;
  localparam int XH_W   = 39;
  localparam int MN_W   = 55;
  localparam int N_W    = 48;
  localparam int T_W    = 64;

  localparam logic [6:0] DIV_STEPS = 7'd64;
  localparam logic [5:0] SQ_STEPS  = 6'd32;
  localparam logic [DIV_W-1:0] INV_NUM = DIV_W'(1) << 48;
  localparam logic signed [PLO_W-1:0] PLO_HALF = PLO_W'(1) << 23;
  localparam logic signed [MN_W-1:0]  MN_HALF  = MN_W'(128);
  localparam logic signed [T_W-1:0]   T_HALF   = T_W'(32768);
  localparam logic signed [T_W-1:0]   Y_MAX    = T_W'(32767);
  localparam logic signed [T_W-1:0]   Y_MIN    = -T_W'(32768);

  typedef enum logic [3:0] {
    S_IDLE, S_DQ, S_SS, S_MDIV, S_VDIV, S_SQRT, S_IDIV,
    S_RD, S_DIFF, S_PLO, S_PHI, S_XH, S_N, S_T, S_Y
  } state_t;

  function automatic logic [63:0] sqrt_in(input logic [V_W-1:0] v);
    logic [V_W-1:0] vf;
    vf = (v == '0) ? V_W'(1) : v;
    return {vf, 24'b0};
  endfunction

  // configuration
  logic               mode_r;
  logic [23:0]        eps_r;
  logic signed [15:0] alpha_r;
  logic signed [15:0] beta_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= nia_pkg::MODE_RST;
      eps_r   <= nia_pkg::EPS_RST;
      alpha_r <= nia_pkg::ALPHA_RST;
      beta_r  <= nia_pkg::BETA_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        nia_pkg::REG_MODE:  mode_r  <= pwdata[0];
        nia_pkg::REG_EPS:   eps_r   <= pwdata[23:0];
        nia_pkg::REG_ALPHA: alpha_r <= pwdata[15:0];
        nia_pkg::REG_BETA:  beta_r  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      nia_pkg::REG_MODE:  prdata = {31'b0, mode_r};
      nia_pkg::REG_EPS:   prdata = {8'b0, eps_r};
      nia_pkg::REG_ALPHA: prdata = {{16{alpha_r[15]}}, alpha_r};
      nia_pkg::REG_BETA:  prdata = {{16{beta_r[15]}}, beta_r};
      default:            prdata = '0;
    endcase
  end

  // datapath state
  state_t               state_r;
  logic                 layer_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     idx_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]      sqsum_r;
  logic                 ovr_r;
  logic [DQ_W-1:0]      dq_r;
  logic [DD_W-1:0]      dd_r;
  logic signed [SS_W-1:0] ss_r;
  logic                 mean_neg_r;
  logic signed [D_W-1:0] mean_r;
  logic [INV_W-1:0]     inv_r;
  logic signed [D_W-1:0] d_r;
  logic signed [15:0]   sc_r;
  logic signed [15:0]   bi_r;
  logic signed [15:0]   pr_r;
  logic signed [PLO_W-1:0] p_lo_r;
  logic signed [PHI_W-1:0] p_hi_r;
  logic signed [31:0]   bp_r;
  logic signed [XH_W-1:0] xh_r;
  logic signed [N_W-1:0]  n_r;
  logic signed [T_W-1:0]  t_r;
  logic                 out_valid_r;
  nia_pkg::out_t        out_r;

  // shared divider
  logic [DIV_W-1:0]     div_quo_r;
  logic [DSR_W:0]       div_rem_r;
  logic [DSR_W-1:0]     div_dsr_r;
  logic [6:0]           div_cnt_r;
  logic [DSR_W+1:0]     div_sh;
  logic                 div_ge;
  logic [DSR_W:0]       div_rem_nxt;
  logic [DIV_W-1:0]     div_quo_nxt;

  // square root
  logic [63:0]          sq_n_r;
  logic [33:0]          sq_rem_r;
  logic [31:0]          sq_root_r;
  logic [5:0]           sq_cnt_r;
  logic [35:0]          sq_sh;
  logic [35:0]          sq_trial;
  logic                 sq_ge;
  logic [33:0]          sq_rem_nxt;
  logic [31:0]          sq_root_nxt;

  // element buffer
  logic [63:0]          mem [MAX_ELEMS];
  logic [63:0]          mem_rd_r;
  logic                 mem_we;
  logic                 has_room;

  logic signed [31:0]   x_sq;
  logic [V_W-1:0]       v_pc;
  logic [NUM_W-1:0]     num_c;
  logic signed [A_W-1:0] mean_a;
  logic [A_W-1:0]       mean_abs;
  logic signed [D_W-1:0] mean_c;
  logic signed [PLO_W-1:0] p_lo_nxt;
  logic signed [PHI_W-1:0] p_hi_nxt;
  logic signed [XH_W-1:0]  xh_nxt;
  logic signed [N_W-1:0]   n_nxt;
  logic signed [T_W-1:0]   t_nxt;
  logic signed [T_W-1:0]   u_c;
  logic signed [T_W-1:0]   y_w;
  logic signed [15:0]      y_sat;
  logic                 el_last;
  logic                 out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  assign has_room = count_r < CNT_W'(MAX_ELEMS);
  assign mem_we   = in_valid && in_ready && mode_r && has_room;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[ADDR_W-1:0]] <= {in_data.x_value, in_data.prior_y,
                                   in_data.scale, in_data.bias};
    end
    mem_rd_r <= mem[idx_r[ADDR_W-1:0]];
  end

  assign div_sh      = {div_rem_r, div_quo_r[DIV_W-1]};
  assign div_ge      = div_sh >= {2'b0, div_dsr_r};
  assign div_rem_nxt = div_ge ? (DSR_W+1)'(div_sh - {2'b0, div_dsr_r}) : (DSR_W+1)'(div_sh);
  assign div_quo_nxt = {div_quo_r[DIV_W-2:0], div_ge};

  assign sq_sh       = {sq_rem_r, sq_n_r[63:62]};
  assign sq_trial    = {2'b0, sq_root_r, 2'b01};
  assign sq_ge       = sq_sh >= sq_trial;
  assign sq_rem_nxt  = sq_ge ? 34'(sq_sh - sq_trial) : 34'(sq_sh);
  assign sq_root_nxt = {sq_root_r[30:0], sq_ge};

  assign x_sq   = in_data.x_value * in_data.x_value;
  assign v_pc   = V_W'({in_data.variance_value, 16'b0}) + V_W'(eps_r);
  assign num_c  = NUM_W'(dq_r) - $unsigned(ss_r);
  assign mean_a = (A_W'(sum_r) <<< 8) + $signed(A_W'(count_r >> 1));
  assign mean_abs = mean_a[A_W-1] ? $unsigned(-mean_a) : $unsigned(mean_a);
  assign mean_c = mean_neg_r
                ? -($signed(D_W'(div_quo_r)) + $signed(D_W'(div_rem_r != '0)))
                : $signed(D_W'(div_quo_r));

  assign p_lo_nxt = PLO_W'(d_r) * PLO_W'($signed({1'b0, inv_r[23:0]}));
  assign p_hi_nxt = PHI_W'(d_r) * PHI_W'($signed({1'b0, inv_r[INV_W-1:24]}));
  assign xh_nxt   = XH_W'(p_hi_r) + XH_W'((p_lo_r + PLO_HALF) >>> 24);
  assign n_nxt    = N_W'((MN_W'(sc_r) * MN_W'(xh_r) + MN_HALF) >>> 8) + (N_W'(bi_r) <<< 8);
  assign t_nxt    = T_W'(alpha_r) * T_W'(n_r);
  assign u_c      = t_r + (T_W'(bp_r) <<< 8) + T_HALF;
  assign y_w      = u_c >>> 16;
  assign y_sat    = (y_w > Y_MAX) ? 16'sh7fff : (y_w < Y_MIN) ? 16'sh8000 : y_w[15:0];
  assign el_last  = !layer_r || (idx_r == count_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      sum_r       <= '0;
      sqsum_r     <= '0;
      ovr_r       <= 1'b0;
      div_cnt_r   <= '0;
      sq_cnt_r    <= '0;
      layer_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_Y) out_valid_r <= 1'b0;
      if (div_cnt_r != '0) begin
        div_rem_r <= div_rem_nxt;
        div_quo_r <= div_quo_nxt;
        div_cnt_r <= div_cnt_r - 7'd1;
      end
      if (sq_cnt_r != '0) begin
        sq_rem_r  <= sq_rem_nxt;
        sq_root_r <= sq_root_nxt;
        sq_n_r    <= {sq_n_r[61:0], 2'b00};
        sq_cnt_r  <= sq_cnt_r - 6'd1;
      end
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          if (!mode_r) begin
            layer_r   <= 1'b0;
            d_r       <= (D_W'(in_data.x_value) - D_W'(in_data.mean_value)) <<< 8;
            sc_r      <= in_data.scale;
            bi_r      <= in_data.bias;
            pr_r      <= in_data.prior_y;
            sq_n_r    <= sqrt_in(v_pc);
            sq_rem_r  <= '0;
            sq_root_r <= '0;
            sq_cnt_r  <= SQ_STEPS;
            state_r   <= S_SQRT;
          end else begin
            layer_r <= 1'b1;
            if (has_room) begin
              sum_r   <= sum_r + SUM_W'(in_data.x_value);
              sqsum_r <= sqsum_r + SQ_W'($unsigned(x_sq));
              count_r <= count_r + CNT_W'(1);
            end else begin
              ovr_r <= 1'b1;
            end
            if (in_data.last) state_r <= S_DQ;
          end
        end
        S_DQ: begin
          dq_r    <= DQ_W'(count_r) * DQ_W'(sqsum_r);
          dd_r    <= DD_W'(count_r) * DD_W'(count_r);
          state_r <= S_SS;
        end
        S_SS: begin
          ss_r       <= SS_W'(sum_r) * SS_W'(sum_r);
          mean_neg_r <= mean_a[A_W-1];
          div_quo_r  <= DIV_W'(mean_abs);
          div_rem_r  <= '0;
          div_dsr_r  <= DSR_W'(count_r);
          div_cnt_r  <= DIV_STEPS;
          state_r    <= S_MDIV;
        end
        S_MDIV: if (div_cnt_r == '0) begin
          mean_r    <= mean_c;
          div_quo_r <= DIV_W'({num_c, 8'b0});
          div_rem_r <= '0;
          div_dsr_r <= DSR_W'(dd_r);
          div_cnt_r <= DIV_STEPS;
          state_r   <= S_VDIV;
        end
        S_VDIV: if (div_cnt_r == '0) begin
          sq_n_r    <= sqrt_in(V_W'(div_quo_r) + V_W'(eps_r));
          sq_rem_r  <= '0;
          sq_root_r <= '0;
          sq_cnt_r  <= SQ_STEPS;
          state_r   <= S_SQRT;
        end
        S_SQRT: if (sq_cnt_r == '0) begin
          div_quo_r <= INV_NUM;
          div_rem_r <= '0;
          div_dsr_r <= sq_root_r;
          div_cnt_r <= DIV_STEPS;
          state_r   <= S_IDIV;
        end
        S_IDIV: if (div_cnt_r == '0) begin
          inv_r   <= INV_W'(div_quo_r);
          idx_r   <= '0;
          state_r <= layer_r ? S_RD : S_PLO;
        end
        S_RD: state_r <= S_DIFF;
        S_DIFF: begin
          d_r     <= (D_W'($signed(mem_rd_r[63:48])) <<< 8) - mean_r;
          pr_r    <= mem_rd_r[47:32];
          sc_r    <= mem_rd_r[31:16];
          bi_r    <= mem_rd_r[15:0];
          state_r <= S_PLO;
        end
        S_PLO: begin
          p_lo_r  <= p_lo_nxt;
          state_r <= S_PHI;
        end
        S_PHI: begin
          p_hi_r  <= p_hi_nxt;
          bp_r    <= beta_r * pr_r;
          state_r <= S_XH;
        end
        S_XH: begin
          xh_r    <= xh_nxt;
          state_r <= S_N;
        end
        S_N: begin
          n_r     <= n_nxt;
          state_r <= S_T;
        end
        S_T: begin
          t_r     <= t_nxt;
          state_r <= S_Y;
        end
        S_Y: if (out_free) begin
          out_valid_r    <= 1'b1;
          out_r.y_value  <= y_sat;
          out_r.last_out <= el_last;
          out_r.overrun  <= layer_r && ovr_r;
          if (!el_last) begin
            idx_r   <= idx_r + CNT_W'(1);
            state_r <= S_RD;
          end else begin
            if (layer_r) begin
              sum_r   <= '0;
              sqsum_r <= '0;
              count_r <= '0;
              ovr_r   <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end else if (out_valid_r && out_ready) begin
          out_valid_r <= 1'b0;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ELEMS))
    else $error("element count beyond buffer depth");

  a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (div_cnt_r == '0 && sq_cnt_r == '0))
    else $error("divider or square root busy while idle");

  a_emit_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Y && out_free && !el_last) |=> (state_r == S_RD && out_valid_r))
    else $error("sample emission did not continue after transfer");

endmodule
